// ===== src/lat_pkg.sv =====
// shared constants and types for the light-triggered alarm timer
`default_nettype none

package lat_pkg;

  // millisecond time base width
  localparam int unsigned TIME_BITS = 32;

  localparam int unsigned LEVEL_W     = 10;
  localparam int unsigned DWELL_W     = 16;
  localparam int unsigned COUNTDOWN_W = 24;
  localparam int unsigned PHASE_W     = 2;
  localparam int unsigned TONE_W      = 11;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 24;

  typedef logic [TIME_BITS-1:0]   time_t;
  typedef logic [LEVEL_W-1:0]     level_t;
  typedef logic [DWELL_W-1:0]     dwell_t;
  typedef logic [COUNTDOWN_W-1:0] countdown_t;
  typedef logic [PHASE_W-1:0]     phase_code_t;
  typedef logic [TONE_W-1:0]      tone_t;
  typedef logic [CFG_IDX_W-1:0]   cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0]  cfg_data_t;

  // configuration register indexes
  localparam cfg_idx_t CFG_REFERENCE = 2'd0;
  localparam cfg_idx_t CFG_THRESHOLD = 2'd1;
  localparam cfg_idx_t CFG_DWELL     = 2'd2;
  localparam cfg_idx_t CFG_COUNTDOWN = 2'd3;

  // configuration reset values
  localparam level_t     REFERENCE_RST = 10'd512;
  localparam level_t     THRESHOLD_RST = 10'd200;
  localparam dwell_t     DWELL_RST     = 16'd1000;
  localparam countdown_t COUNTDOWN_RST = 24'd1800000;

  // counter bits that drive the blink and the tone gate
  localparam int unsigned BLINK_LO = 10;
  localparam int unsigned BLINK_HI = 11;
  localparam int unsigned TONE_LOW_W = 10;
  localparam tone_t       TONE_BASE = 11'd1000;

endpackage

`default_nettype wire

// ===== src/light_triggered_alarm_timer.sv =====
// light-triggered alarm timer: one tick transaction in, one result transaction out
// the result register loads at the edge that takes the tick, released as it is taken
// throughput: one tick per cycle while out_ready is high; ticks stall on a held result
// reset: synchronous active-low rst_n clears phase, time, dwell and led state,
// restores the configuration registers to their defaults and empties the output
`default_nettype none

module light_triggered_alarm_timer (
  input  wire                      clk,
  input  wire                      rst_n,
  // tick channel
  input  wire                      in_valid,
  output logic                     in_ready,
  input  wire  lat_pkg::level_t    in_light_sample,
  // result channel
  output logic                     out_valid,
  input  wire                      out_ready,
  output lat_pkg::phase_code_t     out_phase,
  output logic                     out_led_on,
  output logic                     out_buzzer_on,
  output lat_pkg::tone_t           out_tone_hz,
  // configuration write channel
  input  wire                      cfg_valid,
  output logic                     cfg_ready,
  input  wire  lat_pkg::cfg_idx_t  cfg_index,
  input  wire  lat_pkg::cfg_data_t cfg_data
);
  import lat_pkg::*;

  typedef enum logic [PHASE_W-1:0] {
    PH_IDLE = 2'd0,
    PH_RUN  = 2'd1,
    PH_RING = 2'd2
  } phase_t;

  // configuration registers
  level_t     ref_level_r;
  level_t     drop_thr_r;
  dwell_t     dwell_ms_r;
  countdown_t countdown_ms_r;

  // timer state
  phase_t phase_r,        phase_nxt;
  time_t  now_r;
  logic   armed_r,        armed_nxt;
  time_t  dwell_start_r,  dwell_start_nxt;
  time_t  cd_start_r,     cd_start_nxt;
  logic   led_r,          led_nxt;

  // result register
  logic        out_valid_r;
  phase_code_t out_phase_r;
  logic        out_led_r;
  logic        out_buzzer_r, buzzer_nxt;
  tone_t       out_tone_r,   tone_nxt;

  logic   in_acc;
  level_t drop_level;
  logic   dwell_active;
  logic   dwell_cond;
  logic   dwell_expired;
  logic   dwell_fire;
  logic   cd_expired;
  logic   blink_dark;
  time_t  dwell_end;
  time_t  cd_end;

  // output register frees up when its contents are taken
  assign in_ready  = !out_valid_r || out_ready;
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  assign out_valid     = out_valid_r;
  assign out_phase     = out_phase_r;
  assign out_led_on    = out_led_r;
  assign out_buzzer_on = out_buzzer_r;
  assign out_tone_hz   = out_tone_r;

  // dark trigger level, saturating at zero
  assign drop_level = (ref_level_r >= drop_thr_r) ? level_t'(ref_level_r - drop_thr_r)
                                                  : '0;

  // expiry compares: end time wraps with the counter, no other wrap handling
  assign dwell_end     = time_t'(dwell_start_r + time_t'(dwell_ms_r));
  assign cd_end        = time_t'(cd_start_r + time_t'(countdown_ms_r));
  assign dwell_expired = dwell_end < now_r;
  assign cd_expired    = cd_end < now_r;

  // one dwell qualifier shared by the dark trigger (idle) and light trigger (ringing)
  assign dwell_active = (phase_r == PH_IDLE) || (phase_r == PH_RING);
  assign dwell_cond   = (phase_r == PH_RING) ? (in_light_sample >= ref_level_r)
                                             : (in_light_sample <= drop_level);
  assign dwell_fire   = dwell_active && dwell_cond && armed_r && dwell_expired;

  // blink and tone gate both follow counter bits 10 and 11
  assign blink_dark = |now_r[BLINK_HI:BLINK_LO];

  always_comb begin
    phase_nxt       = phase_r;
    armed_nxt       = armed_r;
    dwell_start_nxt = dwell_start_r;
    cd_start_nxt    = cd_start_r;
    led_nxt         = led_r;
    buzzer_nxt      = 1'b0;
    tone_nxt        = '0;

    // dwell tracking: restart on a broken condition, arm on its first tick
    if (dwell_active) begin
      if (!dwell_cond) begin
        armed_nxt = 1'b0;
      end else if (!armed_r) begin
        armed_nxt       = 1'b1;
        dwell_start_nxt = now_r;
      end else if (dwell_expired) begin
        armed_nxt       = 1'b0;
        dwell_start_nxt = '0;
      end
    end

    case (phase_r)
      PH_IDLE: begin
        // led keeps its level on the tick that starts the countdown
        if (dwell_fire) begin
          cd_start_nxt = now_r;
          phase_nxt    = PH_RUN;
        end
      end
      PH_RUN: begin
        led_nxt = !blink_dark;
        if (cd_expired) begin
          led_nxt   = 1'b0;
          phase_nxt = PH_RING;
        end
      end
      PH_RING: begin
        led_nxt = 1'b1;
        if (blink_dark) begin
          buzzer_nxt = 1'b1;
          tone_nxt   = tone_t'(TONE_BASE + tone_t'(now_r[TONE_LOW_W-1:0]));
        end
        // light held long enough: silence and go back to idle
        if (dwell_fire) begin
          buzzer_nxt      = 1'b0;
          tone_nxt        = '0;
          led_nxt         = 1'b0;
          phase_nxt       = PH_IDLE;
          armed_nxt       = 1'b0;
          dwell_start_nxt = '0;
          cd_start_nxt    = '0;
        end
      end
      default: begin
        // unused phase code: dark and silent, phase holds
        led_nxt = 1'b0;
      end
    endcase
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_level_r    <= REFERENCE_RST;
      drop_thr_r     <= THRESHOLD_RST;
      dwell_ms_r     <= DWELL_RST;
      countdown_ms_r <= COUNTDOWN_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_REFERENCE: ref_level_r    <= cfg_data[LEVEL_W-1:0];
        CFG_THRESHOLD: drop_thr_r     <= cfg_data[LEVEL_W-1:0];
        CFG_DWELL:     dwell_ms_r     <= cfg_data[DWELL_W-1:0];
        CFG_COUNTDOWN: countdown_ms_r <= cfg_data[COUNTDOWN_W-1:0];
        default: ;
      endcase
    end
  end

  // timer state, advanced once per tick transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      now_r         <= '0;
      armed_r       <= 1'b0;
      dwell_start_r <= '0;
      cd_start_r    <= '0;
      led_r         <= 1'b0;
    end else if (in_acc) begin
      phase_r       <= phase_nxt;
      now_r         <= time_t'(now_r + time_t'(1));
      armed_r       <= armed_nxt;
      dwell_start_r <= dwell_start_nxt;
      cd_start_r    <= cd_start_nxt;
      led_r         <= led_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_phase_r  <= phase_code_t'(phase_nxt);
      out_led_r    <= led_nxt;
      out_buzzer_r <= buzzer_nxt;
      out_tone_r   <= tone_nxt;
    end
  end

  // buzzer only sounds while ringing
  a_buzz_ring: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_buzzer_r |-> out_phase_r == phase_code_t'(PH_RING))
    else $error("buzzer on outside ringing");

  // a tone is reported exactly when the buzzer sounds
  a_tone_buzz: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_buzzer_r == (out_tone_r != '0)))
    else $error("tone and buzzer disagree");

  // a sounding buzzer always comes with the led lit
  a_buzz_led: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_buzzer_r |-> out_led_r)
    else $error("led dark while buzzing");

  // idle never jumps straight to ringing
  a_no_skip: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && phase_r == PH_IDLE |=> phase_r != PH_RING)
    else $error("idle went straight to ringing");

  // millisecond counter advances by one per tick transaction
  a_now_step: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> now_r == time_t'($past(now_r) + time_t'(1)))
    else $error("time counter did not advance");

endmodule

`default_nettype wire
